// ----- hw/rtl/qse_pkg.sv -----
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and constants of the quicksort engine: beat structs, range
// stack control and the sequencer state encoding.
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int MAX_ITEMS     = 64;
  localparam int DATA_WIDTH    = 32;
  localparam int IDX_W         = $clog2(MAX_ITEMS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int STACK_SLOTS   = 64;
  localparam int STK_W         = $clog2(STACK_SLOTS);
  localparam int STK_CNT_W     = STK_W + 1;
  localparam int PIVOT_OFFSET  = 2;
  localparam int SMALL_SECTION = 3;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         is_last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         end_of_list;
    logic                         overflowed;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_POP,
    ST_POP_WAIT,
    ST_PART,
    ST_SW1_A,
    ST_SW1_B,
    ST_SW1_W1,
    ST_SW1_W2,
    ST_PIV_RD,
    ST_PIV_CAP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_W1,
    ST_SCAN_W2,
    ST_FIN_RD,
    ST_FIN_W1,
    ST_FIN_W2,
    ST_FIN_PUSH2,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

// ----- hw/rtl/qse_range_stack.sv -----
// ----------------------------------------------------------------------------
// qse_range_stack
// LIFO of pending index ranges for the sort. One push or one pop per cycle;
// popped range shows on pop_range the cycle after the pop.
// ----------------------------------------------------------------------------
module qse_range_stack (
  input  logic              clk,
  input  logic              rst,
  input  qse_pkg::stk_ctl_t ctl,
  input  qse_pkg::range_t   push_range,
  output qse_pkg::range_t   pop_range,
  output logic              empty
);
  import qse_pkg::*;

  range_t               mem [STACK_SLOTS];
  logic [STK_CNT_W-1:0] depth;
  logic [STK_CNT_W-1:0] depth_dec;

  assign depth_dec = depth - STK_CNT_W'(1);
  assign empty     = (depth == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.push && depth < STK_CNT_W'(STACK_SLOTS)) begin
      depth <= depth + STK_CNT_W'(1);
    end else if (ctl.pop && !empty) begin
      depth <= depth_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && depth < STK_CNT_W'(STACK_SLOTS)) begin
      mem[depth[STK_W-1:0]] <= push_range;
    end
    pop_range <= mem[depth_dec[STK_W-1:0]];
  end

endmodule

// ----- hw/rtl/quicksort_engine_top.sv -----
// ----------------------------------------------------------------------------
// quicksort_engine_top
// Collects signed values, sorts them in place with a Lomuto quicksort
// driven by an explicit range stack, then streams them out ascending.
//
//   channel  | signals                        | handshake
//   ---------+--------------------------------+----------------------------
//   item     | item.value, item.is_last       | start && !busy
//   result   | result.sorted_value/.end_of_   | result_strobe, one cycle,
//            | list/.overflowed               | no back-pressure
//
// Loading takes back-to-back beats. A beat with is_last starts the sort; the
// block stays busy until the last result. Each partition may first swap the
// pivot in from offset two, then reads and compares each scanned element and
// swaps each element moved left over two writes, since the element store has
// one read and one write port. Emission then streams the store out in order.
// Synchronous reset empties the store and stack; the receiver cannot stall.
// ----------------------------------------------------------------------------
module quicksort_engine_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  qse_pkg::item_t   item,
  output logic             busy,
  output logic             result_strobe,
  output qse_pkg::result_t result
);
  import qse_pkg::*;

  state_t state, state_next;

  logic signed [DATA_WIDTH-1:0] store [MAX_ITEMS];
  logic signed [DATA_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]             raddr;
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic signed [DATA_WIDTH-1:0] wdata;

  logic [CNT_W-1:0]             count;
  logic                         ovf;
  logic [IDX_W-1:0]             lo, hi, i, p, k;
  logic signed [DATA_WIDTH-1:0] pivot, tmp;

  stk_ctl_t stk_ctl;
  range_t   stk_push, stk_pop;
  logic     stk_empty;

  logic             le_pivot;
  logic             big_section;
  logic [CNT_W-1:0] p_inc;
  logic             push_right, push_left;
  logic             emit_last;
  logic             accept;

  assign accept      = start && !busy;
  assign le_pivot    = (rdata <= pivot);
  assign big_section = ({1'b0, hi} - {1'b0, lo} + CNT_W'(1)) > CNT_W'(SMALL_SECTION);
  assign p_inc       = {1'b0, p} + CNT_W'(1);
  assign push_right  = p_inc < {1'b0, hi};
  assign push_left   = {1'b0, p} > ({1'b0, lo} + CNT_W'(1));
  assign emit_last   = ({1'b0, k} + CNT_W'(1)) == count;

  qse_range_stack u_stack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (stk_ctl),
    .push_range (stk_push),
    .pop_range  (stk_pop),
    .empty      (stk_empty)
  );

  // element store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:      if (accept && item.is_last) state_next = ST_SORT_INIT;
      ST_SORT_INIT: state_next = (count < CNT_W'(2)) ? ST_EMIT_RD : ST_POP;
      ST_POP:       state_next = stk_empty ? ST_EMIT_RD : ST_POP_WAIT;
      ST_POP_WAIT:  state_next = ST_PART;
      ST_PART:      state_next = big_section ? ST_SW1_A : ST_PIV_RD;
      ST_SW1_A:     state_next = ST_SW1_B;
      ST_SW1_B:     state_next = ST_SW1_W1;
      ST_SW1_W1:    state_next = ST_SW1_W2;
      ST_SW1_W2:    state_next = ST_SCAN_RD;
      ST_PIV_RD:    state_next = ST_PIV_CAP;
      ST_PIV_CAP:   state_next = ST_SCAN_RD;
      ST_SCAN_RD:   state_next = (i == hi) ? ST_FIN_RD : ST_SCAN_CMP;
      ST_SCAN_CMP:  state_next = le_pivot ? ST_SCAN_W1 : ST_SCAN_RD;
      ST_SCAN_W1:   state_next = ST_SCAN_W2;
      ST_SCAN_W2:   state_next = ST_SCAN_RD;
      ST_FIN_RD:    state_next = ST_FIN_W1;
      ST_FIN_W1:    state_next = ST_FIN_W2;
      ST_FIN_W2:    state_next = ST_FIN_PUSH2;
      ST_FIN_PUSH2: state_next = ST_POP;
      ST_EMIT_RD:   state_next = ST_EMIT_OUT;
      ST_EMIT_OUT:  if (emit_last) state_next = ST_LOAD;
      default:      state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    raddr         = i;
    we            = 1'b0;
    waddr         = count[IDX_W-1:0];
    wdata         = item.value;
    stk_ctl       = '0;
    stk_push.lo   = lo;
    stk_push.hi   = hi;
    busy          = 1'b1;
    result_strobe = 1'b0;
    result.sorted_value = rdata;
    result.end_of_list  = emit_last;
    result.overflowed   = ovf;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        we   = accept && (count < CNT_W'(MAX_ITEMS));
      end
      ST_SORT_INIT: begin
        stk_ctl.push = (count >= CNT_W'(2));
        stk_push.lo  = '0;
        stk_push.hi  = IDX_W'(count - CNT_W'(1));
      end
      ST_POP:    stk_ctl.pop = 1'b1;
      ST_SW1_A:  raddr = lo + IDX_W'(PIVOT_OFFSET);
      ST_SW1_B:  raddr = hi;
      ST_SW1_W1: begin
        we    = 1'b1;
        waddr = lo + IDX_W'(PIVOT_OFFSET);
        wdata = rdata;
      end
      ST_SW1_W2: begin
        we    = 1'b1;
        waddr = hi;
        wdata = tmp;
      end
      ST_PIV_RD:   raddr = hi;
      ST_SCAN_RD:  raddr = i;
      ST_SCAN_CMP: raddr = p;
      ST_SCAN_W1: begin
        we    = 1'b1;
        waddr = i;
        wdata = rdata;
      end
      ST_SCAN_W2: begin
        we    = 1'b1;
        waddr = p;
        wdata = tmp;
      end
      ST_FIN_RD: raddr = p;
      ST_FIN_W1: begin
        we    = 1'b1;
        waddr = hi;
        wdata = rdata;
      end
      ST_FIN_W2: begin
        we           = 1'b1;
        waddr        = p;
        wdata        = pivot;
        stk_ctl.push = push_right;
        stk_push.lo  = p_inc[IDX_W-1:0];
      end
      ST_FIN_PUSH2: begin
        stk_ctl.push = push_left;
        stk_push.hi  = p - IDX_W'(1);
      end
      ST_EMIT_RD:  raddr = '0;
      ST_EMIT_OUT: begin
        raddr         = k + IDX_W'(1);
        result_strobe = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (state == ST_LOAD && accept) begin
      if (count < CNT_W'(MAX_ITEMS)) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end else if (state == ST_EMIT_OUT && emit_last) begin
      count <= '0;
      ovf   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_POP_WAIT: begin
        lo <= stk_pop.lo;
        hi <= stk_pop.hi;
      end
      ST_SW1_B: tmp <= rdata;
      ST_SW1_W2: begin
        // swapped-in element is the pivot
        pivot <= tmp;
        i     <= lo;
        p     <= lo;
      end
      ST_PIV_RD: begin
        i <= lo;
        p <= lo;
      end
      ST_PIV_CAP: pivot <= rdata;
      ST_SCAN_CMP: begin
        tmp <= rdata;
        if (!le_pivot) i <= i + IDX_W'(1);
      end
      ST_SCAN_W2: begin
        i <= i + IDX_W'(1);
        p <= p + IDX_W'(1);
      end
      ST_EMIT_RD:  k <= '0;
      ST_EMIT_OUT: k <= k + IDX_W'(1);
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/qse_checker.sv -----
// ----------------------------------------------------------------------------
// qse_checker
// Port-level checks of the quicksort engine: run framing and output order.
// ----------------------------------------------------------------------------
module qse_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input qse_pkg::item_t   item,
  input logic             busy,
  input logic             result_strobe,
  input qse_pkg::result_t result
);
  import qse_pkg::*;

  // a beat with is_last always starts a busy sort/emit phase
  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.is_last |=> busy)
    else $error("busy did not rise after last beat");

  // results only appear while busy
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe while idle");

  // the end-of-list beat releases the block
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.end_of_list |=> !busy)
    else $error("still busy after end of list");

  // consecutive beats of one run come out ascending
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !$past(rst) && $past(result_strobe) && !$past(result.end_of_list)
    |-> $past(result.sorted_value) <= result.sorted_value)
    else $error("results out of order");

  // overflow flag is constant across a run
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !$past(rst) && $past(result_strobe) && !$past(result.end_of_list)
    |-> result.overflowed == $past(result.overflowed))
    else $error("overflow flag changed within a run");

endmodule

bind quicksort_engine_top qse_checker u_qse_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .item          (item),
  .busy          (busy),
  .result_strobe (result_strobe),
  .result        (result)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quicksort_engine_top. Lists of signed values are
// sent as beats, each list closed by a beat with is_last. A local sort of
// the same lists predicts every result beat, and the monitor compares them
// in order. Directed lists hit the value extremes, duplicates and the
// pivot swap. Random lists follow, some filling the store or overrunning it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qse_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEM_TARGET = 450;
  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef struct {
    item_t beat;
    bit    drain_first;   // hold off until every pending result is out
  } queued_beat_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    result_strobe;
  result_t result;

  quicksort_engine_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_strobe(result_strobe),
    .result       (result)
  );

  always #1 clk = ~clk;

  queued_beat_t pending[$];
  result_t      sorted_due[$];

  // predictor state
  logic signed [DATA_WIDTH-1:0] held_vals[MAX_ITEMS];
  int unsigned held_count = 0;
  bit          drop_seen = 1'b0;

  bit          beat_taken = 1'b0;
  int unsigned beats_in = 0;
  int unsigned lists_sorted = 0;
  int unsigned lists_overrun = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic void swap_held(int a, int b);
    logic signed [DATA_WIDTH-1:0] t;
    t            = held_vals[a];
    held_vals[a] = held_vals[b];
    held_vals[b] = t;
  endfunction

  // Lomuto quicksort over an explicit range stack, pivot taken from offset
  // two in sections larger than three.
  function automatic void quicksort_held();
    int lo_stk[$];
    int hi_stk[$];
    int lo, hi, p;
    logic signed [DATA_WIDTH-1:0] piv;
    if (held_count < 2) return;
    lo_stk.push_back(0);
    hi_stk.push_back(held_count - 1);
    while (lo_stk.size() > 0) begin
      lo = lo_stk.pop_back();
      hi = hi_stk.pop_back();
      if (hi - lo + 1 > SMALL_SECTION) swap_held(lo + PIVOT_OFFSET, hi);
      piv = held_vals[hi];
      p   = lo;
      for (int i = lo; i < hi; i++) begin
        if (held_vals[i] <= piv) begin
          swap_held(i, p);
          p++;
        end
      end
      swap_held(p, hi);
      if (p + 1 < hi) begin
        lo_stk.push_back(p + 1);
        hi_stk.push_back(hi);
      end
      if (p > lo + 1) begin
        lo_stk.push_back(lo);
        hi_stk.push_back(p - 1);
      end
    end
  endfunction

  function automatic void absorb_beat(item_t b);
    result_t r;
    if (held_count < MAX_ITEMS) begin
      held_vals[held_count] = b.value;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!b.is_last) return;
    quicksort_held();
    for (int k = 0; k < held_count; k++) begin
      r.sorted_value = held_vals[k];
      r.end_of_list  = (k + 1 == held_count);
      r.overflowed   = drop_seen;
      sorted_due.push_back(r);
    end
    lists_sorted++;
    if (drop_seen) lists_overrun++;
    held_count = 0;
    drop_seen  = 1'b0;
  endfunction

  function automatic void report_miss(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected val=%0d eol=%0b ovf=%0b, got val=%0d eol=%0b ovf=%0b",
               $realtime, what, want.sorted_value, want.end_of_list, want.overflowed,
               got.sorted_value, got.end_of_list, got.overflowed);
  endfunction

  function automatic int sender_idle_pct();
    if (beats_in < 150) return 25;
    if (beats_in < 300) return 62;
    return 0;
  endfunction

  task automatic queue_list(input logic signed [DATA_WIDTH-1:0] vals[$], input bit drain);
    queued_beat_t q;
    foreach (vals[k]) begin
      q.beat.value   = vals[k];
      q.beat.is_last = (k == vals.size() - 1);
      q.drain_first  = drain && (k == 0);
      pending.push_back(q);
    end
  endtask

  // driver: offer the head of the queue, hold it until taken
  always @(negedge clk) begin : drive
    bit hold;
    hold       = start && !beat_taken;
    beat_taken = 1'b0;
    if (!rst && !hold) begin
      if (pending.size() > 0 &&
          !(pending[0].drain_first && (sorted_due.size() != 0 || busy)) &&
          $urandom_range(0, 99) >= sender_idle_pct()) begin
        start <= 1'b1;
        item  <= pending[0].beat;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: beats in feed the predictor, beats out are checked in order
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (result_strobe) begin
        results_checked++;
        if (sorted_due.size() == 0) begin
          report_miss("unexpected result", '0, result);
        end else begin
          want = sorted_due.pop_front();
          if (result !== want) report_miss("result mismatch", want, result);
        end
      end
      if (start && !busy) begin
        beat_taken = 1'b1;
        beats_in++;
        if (pending.size() > 0) void'(pending.pop_front());
        absorb_beat(item);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [DATA_WIDTH-1:0] vals[$];
    int total, len, style, run_idx;
    logic signed [DATA_WIDTH-1:0] base;

    // directed lists
    queue_list('{VAL_MAX}, 1'b0);
    queue_list('{VAL_MIN, VAL_MAX}, 1'b1);
    queue_list('{5, 5, 5}, 1'b0);
    queue_list('{4, 3, 2, 1}, 1'b0);
    queue_list('{0, -1, 1, VAL_MIN, VAL_MAX, 0}, 1'b0);
    queue_list('{-7, 100, -7, 3, 100, 0, VAL_MIN, VAL_MAX}, 1'b1);
    total = 24;

    run_idx = 0;
    while (total < ITEM_TARGET) begin
      if (run_idx == 2) len = MAX_ITEMS;
      else if (run_idx == 6) len = MAX_ITEMS + $urandom_range(1, 4);
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 4);
      else len = $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      base  = $urandom;
      vals.delete();
      for (int k = 0; k < len; k++) begin
        case (style)
          0: vals.push_back($urandom);
          1: vals.push_back($signed($urandom_range(0, 8)) - 4);
          2: vals.push_back(base + k * $urandom_range(0, 3));
          default: begin
            case ($urandom_range(0, 4))
              0: vals.push_back(VAL_MIN);
              1: vals.push_back(VAL_MAX);
              2: vals.push_back(0);
              3: vals.push_back(-1);
              default: vals.push_back($urandom);
            endcase
          end
        endcase
      end
      queue_list(vals, $urandom_range(0, 5) == 0);
      total += len;
      run_idx++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending.size() != 0 || start || sorted_due.size() != 0 || busy);
    repeat (40) @(negedge clk);

    $display("%0d beats in %0d lists (%0d overran the store), %0d results checked",
             beats_in, lists_sorted, lists_overrun, results_checked);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
